// ===== src/tsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Truss stiffness assembler package
// Shared types and fixed widths of the assembler and its arithmetic units.
// ----------------------------------------------------------------------------
package tsa_pkg;

   localparam int ENTRY_W   = 64;  // matrix entry, signed fixed point
   localparam int COORD_W   = 32;  // node coordinate
   localparam int MAG_W     = 32;  // magnitude of a coordinate difference
   localparam int SUMSQ_W   = 66;  // sum of two squared magnitudes
   localparam int ROOT_W    = 33;  // bar length
   localparam int DIV_NUM_W = 96;  // dividend width of the divide / root unit
   localparam int DSU_REM_W = 36;  // partial remainder of the divide / root unit
   localparam int QUO_W     = 64;  // quotient kept by the divide / root unit
   localparam int MUL_W     = 64;  // operand width of the multiword multiplier
   localparam int PROD_W    = 128; // product width of the multiword multiplier
   localparam int COS_BITS  = 30;  // fraction bits of a direction cosine
   localparam int COSM_W    = 31;  // cosine magnitude, up to one
   localparam int TERM_W    = 63;  // magnitude of one stiffness term
   localparam int EA_W      = 48;  // modulus times area

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_LEN  = 2'd1,
      ST_SAME_NODE = 2'd2,
      ST_SAT       = 2'd3
   } status_type;

   // command to the divide / square root unit
   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } dsu_cmd_type;

   // result flags from the divide / square root unit
   typedef struct packed {
      logic done;
      logic ovf;
   } dsu_stat_type;

endpackage

`default_nettype wire

// ===== src/tsa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Truss stiffness assembler channels
// Valid / ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface tsa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [4:0]  start_node;
   logic [4:0]  end_node;
   logic [31:0] start_x;
   logic [31:0] start_y;
   logic [31:0] end_x;
   logic [31:0] end_y;
   logic [23:0] elasticity;
   logic [23:0] area;
   logic [5:0]  row_index;
   logic [5:0]  col_index;

   modport source (output valid, opcode, start_node, end_node, start_x, start_y,
                   end_x, end_y, elasticity, area, row_index, col_index,
                   input ready);
   modport sink   (input valid, opcode, start_node, end_node, start_x, start_y,
                   end_x, end_y, elasticity, area, row_index, col_index,
                   output ready);
endinterface

interface tsa_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] entry_value;
   logic [1:0]  status;

   modport source (output valid, entry_value, status, input ready);
   modport sink   (input valid, entry_value, status, output ready);
endinterface

`default_nettype wire

// ===== src/tsa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/tsa_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multiword multiplier
// 64 x 64 unsigned product from four registered 32 x 32 partial products.
// ----------------------------------------------------------------------------
module tsa_mul (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tsa_pkg::MUL_W-1:0]  a,
   input  wire logic [tsa_pkg::MUL_W-1:0]  b,
   output logic                            done,
   output logic      [tsa_pkg::PROD_W-1:0] prod
);

   localparam int HALF_W = tsa_pkg::MUL_W / 2;

   logic [tsa_pkg::MUL_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, pv_ff, pv_in, done_ff, done_in;
   logic [tsa_pkg::MUL_W-1:0]  pp_ff, pp_in;
   logic [1:0]                 sh_ff, sh_in;
   logic [tsa_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]          ah, bh;

   always_comb begin
      ah      = cnt_ff[1] ? a_ff[tsa_pkg::MUL_W-1:HALF_W] : a_ff[HALF_W-1:0];
      bh      = cnt_ff[0] ? b_ff[tsa_pkg::MUL_W-1:HALF_W] : b_ff[HALF_W-1:0];
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      pv_in   = 1'b0;
      done_in = 1'b0;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      if (start) begin
         a_in    = a;
         b_in    = b;
         cnt_in  = 3'd0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            // form the next partial product
            pp_in  = tsa_pkg::MUL_W'(ah) * tsa_pkg::MUL_W'(bh);
            sh_in  = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
            pv_in  = 1'b1;
            cnt_in = cnt_ff + 3'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (pv_ff) begin
            acc_in = acc_ff + ({{tsa_pkg::MUL_W{1'b0}}, pp_ff} << {sh_ff, 5'd0});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         pv_ff   <= pv_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

// ===== src/tsa_dsu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divide and square root unit
// Restoring shift-subtract divider and digit-by-digit square root on one
// shared subtractor; one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module tsa_dsu (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tsa_pkg::dsu_cmd_type          cmd,
   input  wire logic [tsa_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [tsa_pkg::ROOT_W-1:0]    den,
   output tsa_pkg::dsu_stat_type              stat,
   output logic      [tsa_pkg::QUO_W-1:0]     quo
);

   localparam int RW = tsa_pkg::DSU_REM_W;

   logic [tsa_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [tsa_pkg::ROOT_W-1:0]    den_ff, den_in;
   logic [RW-1:0]                 rem_ff, rem_in;
   logic [tsa_pkg::QUO_W-1:0]     q_ff, q_in;
   logic [6:0]                    cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, sq_ff, sq_in;
   logic                          ovf_ff, ovf_in, done_ff, done_in;
   logic [RW-1:0]                 x, y;
   logic [RW:0]                   diff;
   logic                          ge, last;

   always_comb begin
      x    = sq_ff ? {rem_ff[RW-3:0], num_ff[tsa_pkg::DIV_NUM_W-1 -: 2]}
                   : {rem_ff[RW-2:0], num_ff[tsa_pkg::DIV_NUM_W-1]};
      y    = sq_ff ? {q_ff[RW-3:0], 2'b01}
                   : {{(RW - tsa_pkg::ROOT_W){1'b0}}, den_ff};
      diff = {1'b0, x} - {1'b0, y};
      ge   = ~diff[RW];
      last = sq_ff ? (cnt_ff == 7'(tsa_pkg::ROOT_W - 1))
                   : (cnt_ff == 7'(tsa_pkg::DIV_NUM_W - 1));

      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sq_in   = sq_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
         sq_in   = cmd.sqrt_mode;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[RW-1:0] : x;
         // a bit shifted out of the quotient means it no longer fits
         ovf_in = ovf_ff | q_ff[tsa_pkg::QUO_W-1];
         q_in   = {q_ff[tsa_pkg::QUO_W-2:0], ge};
         num_in = sq_ff ? (num_ff << 2) : (num_ff << 1);
         cnt_in = cnt_ff + 7'd1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
         sq_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         sq_ff   <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff | q_ff[tsa_pkg::QUO_W-1];
   assign quo       = q_ff;

endmodule

`default_nettype wire

// ===== src/truss_stiffness_assembler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Planar truss stiffness assembler
// Keeps the global stiffness matrix of a 2D truss in a RAM and adds one bar
// element per add request; also reads single entries and clears the matrix.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus carries one request per transfer (add bar, read entry, clear);
//  rsp_bus returns exactly one response per request, in order. csr_we writes
//  the unit stiffness mode bit; write it only while the block is idle.
//  Requests are taken one at a time: req_bus.ready is high only in the idle
//  state, and while a finished response waits on a stalled rsp_bus the
//  block keeps accepting the next request and works on it, holding its own
//  response until the output register is free.
//  From acceptance to rsp_bus.valid, a valid read passes S_RDGET
//  and S_FIN; an opcode with no action, an out-of-range read and a skipped
//  bar go straight to S_FIN; a clear sweeps all (2*NODE_COUNT)^2 entries
//  in S_CLR (one entry a cycle) before S_FIN. An add runs two squares and
//  three stiffness terms (two products each) on the 4-pass multiplier, a
//  root and up to three divisions (two in unit mode) on the shared
//  shift-subtract unit, then 16 read-modify-writes, each a read state and
//  a write state, on the single RAM port pair.
//  Reset runs a clearing pass over all (2*NODE_COUNT)^2 entries during
//  which no request is accepted; the mode register resets to zero.
// ----------------------------------------------------------------------------
module truss_stiffness_assembler_core #(
   parameter int NODE_COUNT    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic csr_wdata,
   tsa_req_if.sink   req_bus,
   tsa_rsp_if.source rsp_bus
);

   localparam int DOF_COUNT = 2 * NODE_COUNT;
   localparam int NODE_W    = $clog2(NODE_COUNT);
   localparam int DOF_W     = NODE_W + 1;
   localparam int RAM_DEPTH = DOF_COUNT * DOF_COUNT;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int EW        = tsa_pkg::ENTRY_W;

   localparam logic [EW-1:0] ENTRY_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] ENTRY_MIN = {1'b1, {(EW-1){1'b0}}};

   typedef enum logic [13:0] {
      S_CLR   = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_SQX   = 14'b00000000000100,
      S_SQY   = 14'b00000000001000,
      S_SQRT  = 14'b00000000010000,
      S_DIVK  = 14'b00000000100000,
      S_DIVC  = 14'b00000001000000,
      S_DIVS  = 14'b00000010000000,
      S_PM1   = 14'b00000100000000,
      S_PM2   = 14'b00001000000000,
      S_RD    = 14'b00010000000000,
      S_WR    = 14'b00100000000000,
      S_RDGET = 14'b01000000000000,
      S_FIN   = 14'b10000000000000
   } state_type;

   state_type                          state_ff, state_in;
   logic                               mode_ff, mode_in;
   logic [ADDR_W-1:0]                  clr_ff, clr_in;
   logic                               clr_fin_ff, clr_fin_in;
   logic [tsa_pkg::MAG_W-1:0]          mx_ff, mx_in, my_ff, my_in;
   logic                               negx_ff, negx_in, negy_ff, negy_in;
   logic [NODE_W-1:0]                  na_ff, na_in, nb_ff, nb_in;
   logic [tsa_pkg::EA_W-1:0]           ea_ff, ea_in;
   logic [tsa_pkg::SUMSQ_W-1:0]        sum_ff, sum_in;
   logic [tsa_pkg::ROOT_W-1:0]         len_ff, len_in;
   logic [EW-1:0]                      k_ff, k_in;
   logic [tsa_pkg::COSM_W-1:0]         cx_ff, cx_in, cy_ff, cy_in;
   logic [2*tsa_pkg::COSM_W-1:0]       pm_ff, pm_in;
   logic [2:0][tsa_pkg::TERM_W-1:0]    t_ff, t_in;
   logic [1:0]                         sel_ff, sel_in;
   logic [3:0]                         idx_ff, idx_in;
   logic                               sat_ff, sat_in;
   logic [EW-1:0]                      ent_ff, ent_in;
   tsa_pkg::status_type                stat_ff, stat_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]                      rsp_value_ff, rsp_value_in;
   tsa_pkg::status_type                rsp_stat_ff, rsp_stat_in;
   logic                               mul_go_ff, mul_go_in;
   tsa_pkg::dsu_cmd_type               dsu_cmd_ff, dsu_cmd_in;

   // combinational helpers
   logic                               accept;
   logic [tsa_pkg::MAG_W:0]            dx, dy, dxn, dyn;
   logic [tsa_pkg::MUL_W-1:0]          mul_a, mul_b;
   logic                               mul_done;
   logic [tsa_pkg::PROD_W-1:0]         mul_prod;
   logic [tsa_pkg::DIV_NUM_W-1:0]      dsu_num;
   tsa_pkg::dsu_stat_type              dsu_stat;
   logic [tsa_pkg::QUO_W-1:0]          dsu_quo;
   logic                               ram_we;
   logic [ADDR_W-1:0]                  ram_waddr, ram_raddr, rmw_addr, rd_addr;
   logic [EW-1:0]                      ram_wdata, ram_rdata;
   logic [1:0]                         ti, tj;
   logic [DOF_W-1:0]                   dof_r, dof_c;
   logic                               term_neg;
   logic [tsa_pkg::TERM_W-1:0]         term_mag;
   logic [EW-1:0]                      term, sum_raw, sum_sat;
   logic                               add_ovf;
   logic                               rd_ok;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // element position of the current read-modify-write
   always_comb begin
      ti       = idx_ff[3:2];
      tj       = idx_ff[1:0];
      dof_r    = {(ti[1] ? nb_ff : na_ff), ti[0]};
      dof_c    = {(tj[1] ? nb_ff : na_ff), tj[0]};
      rmw_addr = ADDR_W'(ADDR_W'(dof_r) * ADDR_W'(DOF_COUNT)) + ADDR_W'(dof_c);
      // sign of v_i * v_j: the second node flips both cosines
      term_neg = (ti[0] ? negy_ff : negx_ff) ^ (tj[0] ? negy_ff : negx_ff)
                 ^ ti[1] ^ tj[1];
      case ({ti[0], tj[0]})
         2'b00:   term_mag = t_ff[0];
         2'b11:   term_mag = t_ff[2];
         default: term_mag = t_ff[1];
      endcase
      term     = term_neg ? (EW'(0) - {1'b0, term_mag}) : {1'b0, term_mag};
      sum_raw  = ram_rdata + term;
      add_ovf  = (ram_rdata[EW-1] == term[EW-1]) && (sum_raw[EW-1] != ram_rdata[EW-1]);
      sum_sat  = add_ovf ? (term[EW-1] ? ENTRY_MIN : ENTRY_MAX) : sum_raw;
   end

   // request decoding: read address and bar coordinate differences
   always_comb begin
      rd_ok   = ({26'd0, req_bus.row_index} < 32'(DOF_COUNT))
             && ({26'd0, req_bus.col_index} < 32'(DOF_COUNT));
      rd_addr = ADDR_W'(ADDR_W'(DOF_W'(req_bus.row_index)) * ADDR_W'(DOF_COUNT))
              + ADDR_W'(DOF_W'(req_bus.col_index));
      dx      = {req_bus.end_x[31], req_bus.end_x} - {req_bus.start_x[31], req_bus.start_x};
      dy      = {req_bus.end_y[31], req_bus.end_y} - {req_bus.start_y[31], req_bus.start_y};
      dxn     = (tsa_pkg::MAG_W + 1)'(0) - dx;
      dyn     = (tsa_pkg::MAG_W + 1)'(0) - dy;
   end

   // operand selection for the shared units
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQX: begin
            mul_a = tsa_pkg::MUL_W'(mx_ff);
            mul_b = tsa_pkg::MUL_W'(mx_ff);
         end
         S_SQY: begin
            mul_a = tsa_pkg::MUL_W'(my_ff);
            mul_b = tsa_pkg::MUL_W'(my_ff);
         end
         S_PM1: begin
            mul_a = tsa_pkg::MUL_W'((sel_ff == 2'd2) ? cy_ff : cx_ff);
            mul_b = tsa_pkg::MUL_W'((sel_ff == 2'd0) ? cx_ff : cy_ff);
         end
         S_PM2: begin
            mul_a = k_ff;
            mul_b = tsa_pkg::MUL_W'(pm_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      case (state_ff)
         S_SQRT:  dsu_num = {sum_ff, {(tsa_pkg::DIV_NUM_W - tsa_pkg::SUMSQ_W){1'b0}}};
         S_DIVK:  dsu_num = tsa_pkg::DIV_NUM_W'(ea_ff) << (2 * FRACTION_BITS);
         S_DIVC:  dsu_num = tsa_pkg::DIV_NUM_W'(mx_ff) << tsa_pkg::COS_BITS;
         S_DIVS:  dsu_num = tsa_pkg::DIV_NUM_W'(my_ff) << tsa_pkg::COS_BITS;
         default: dsu_num = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_we ? csr_wdata : mode_ff;
      clr_in       = clr_ff;
      clr_fin_in   = clr_fin_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      ea_in        = ea_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      pm_in        = pm_ff;
      t_in         = t_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      sat_in       = sat_ff;
      ent_in       = ent_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_stat_in  = rsp_stat_ff;
      mul_go_in    = 1'b0;
      dsu_cmd_in   = '0;
      ram_we       = 1'b0;
      ram_waddr    = rmw_addr;
      ram_wdata    = sum_sat;
      ram_raddr    = rmw_addr;

      case (state_ff)
         S_CLR: begin
            // sweep the matrix to zero
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(RAM_DEPTH - 1)) begin
               state_in = clr_fin_ff ? S_FIN : S_IDLE;
            end
         end
         S_IDLE: begin
            ram_raddr = rd_addr;
            if (accept) begin
               ent_in  = '0;
               stat_in = tsa_pkg::ST_OK;
               sat_in  = 1'b0;
               na_in   = NODE_W'(req_bus.start_node);
               nb_in   = NODE_W'(req_bus.end_node);
               mx_in   = dx[tsa_pkg::MAG_W] ? dxn[tsa_pkg::MAG_W-1:0] : dx[tsa_pkg::MAG_W-1:0];
               my_in   = dy[tsa_pkg::MAG_W] ? dyn[tsa_pkg::MAG_W-1:0] : dy[tsa_pkg::MAG_W-1:0];
               negx_in = dx[tsa_pkg::MAG_W];
               negy_in = dy[tsa_pkg::MAG_W];
               ea_in   = tsa_pkg::EA_W'(req_bus.elasticity) * tsa_pkg::EA_W'(req_bus.area);
               state_in = S_FIN;
               case (req_bus.opcode)
                  tsa_pkg::OP_ADD: begin
                     if (req_bus.start_node == req_bus.end_node
                         || 9'(req_bus.start_node) >= 9'(NODE_COUNT)
                         || 9'(req_bus.end_node) >= 9'(NODE_COUNT)) begin
                        stat_in = tsa_pkg::ST_SAME_NODE;
                     end else if (dx == '0 && dy == '0) begin
                        stat_in = tsa_pkg::ST_ZERO_LEN;
                     end else begin
                        mul_go_in = 1'b1;
                        state_in  = S_SQX;
                     end
                  end
                  tsa_pkg::OP_READ: begin
                     if (rd_ok) begin
                        state_in = S_RDGET;
                     end
                  end
                  tsa_pkg::OP_CLEAR: begin
                     clr_in     = '0;
                     clr_fin_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_RDGET: begin
            ent_in   = ram_rdata;
            state_in = S_FIN;
         end
         S_SQX: begin
            if (mul_done) begin
               sum_in    = tsa_pkg::SUMSQ_W'(mul_prod[tsa_pkg::MUL_W-1:0]);
               mul_go_in = 1'b1;
               state_in  = S_SQY;
            end
         end
         S_SQY: begin
            if (mul_done) begin
               sum_in               = sum_ff + tsa_pkg::SUMSQ_W'(mul_prod[tsa_pkg::MUL_W-1:0]);
               dsu_cmd_in.start     = 1'b1;
               dsu_cmd_in.sqrt_mode = 1'b1;
               state_in             = S_SQRT;
            end
         end
         S_SQRT: begin
            if (dsu_stat.done) begin
               len_in           = dsu_quo[tsa_pkg::ROOT_W-1:0];
               dsu_cmd_in.start = 1'b1;
               if (mode_ff) begin
                  k_in     = EW'(1) << FRACTION_BITS;
                  state_in = S_DIVC;
               end else begin
                  state_in = S_DIVK;
               end
            end
         end
         S_DIVK: begin
            if (dsu_stat.done) begin
               // clamp the bar coefficient to the largest entry
               k_in             = dsu_stat.ovf ? ENTRY_MAX : dsu_quo;
               sat_in           = sat_ff | dsu_stat.ovf;
               dsu_cmd_in.start = 1'b1;
               state_in         = S_DIVC;
            end
         end
         S_DIVC: begin
            if (dsu_stat.done) begin
               cx_in            = dsu_quo[tsa_pkg::COSM_W-1:0];
               dsu_cmd_in.start = 1'b1;
               state_in         = S_DIVS;
            end
         end
         S_DIVS: begin
            if (dsu_stat.done) begin
               cy_in     = dsu_quo[tsa_pkg::COSM_W-1:0];
               sel_in    = 2'd0;
               mul_go_in = 1'b1;
               state_in  = S_PM1;
            end
         end
         S_PM1: begin
            if (mul_done) begin
               pm_in     = mul_prod[2*tsa_pkg::COSM_W-1:0];
               mul_go_in = 1'b1;
               state_in  = S_PM2;
            end
         end
         S_PM2: begin
            if (mul_done) begin
               // drop the cosine fraction bits; clamp an oversized term
               if (mul_prod[tsa_pkg::PROD_W-1:2*tsa_pkg::COS_BITS+tsa_pkg::TERM_W] != '0) begin
                  sat_in         = 1'b1;
                  t_in[sel_ff]   = {tsa_pkg::TERM_W{1'b1}};
               end else begin
                  t_in[sel_ff]   = mul_prod[2*tsa_pkg::COS_BITS +: tsa_pkg::TERM_W];
               end
               if (sel_ff == 2'd2) begin
                  idx_in   = 4'd0;
                  state_in = S_RD;
               end else begin
                  sel_in    = sel_ff + 2'd1;
                  mul_go_in = 1'b1;
                  state_in  = S_PM1;
               end
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            // add the term into the entry just read, saturating
            ram_we = 1'b1;
            sat_in = sat_ff | add_ovf;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               stat_in  = (sat_ff | add_ovf) ? tsa_pkg::ST_SAT : tsa_pkg::ST_OK;
               state_in = S_FIN;
            end else begin
               state_in = S_RD;
            end
         end
         S_FIN: begin
            // hold the response until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ent_ff;
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_fin_ff   <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         dsu_cmd_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_fin_ff   <= clr_fin_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_go_ff    <= mul_go_in;
         dsu_cmd_ff   <= dsu_cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      negx_ff      <= negx_in;
      negy_ff      <= negy_in;
      na_ff        <= na_in;
      nb_ff        <= nb_in;
      ea_ff        <= ea_in;
      sum_ff       <= sum_in;
      len_ff       <= len_in;
      k_ff         <= k_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      pm_ff        <= pm_in;
      t_ff         <= t_in;
      sel_ff       <= sel_in;
      idx_ff       <= idx_in;
      sat_ff       <= sat_in;
      ent_ff       <= ent_in;
      stat_ff      <= stat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.entry_value = rsp_value_ff;
   assign rsp_bus.status      = rsp_stat_ff;

   tsa_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go_ff),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   tsa_dsu u_dsu (
      .clock (clock),
      .reset (reset),
      .cmd   (dsu_cmd_ff),
      .num   (dsu_num),
      .den   (len_ff),
      .stat  (dsu_stat),
      .quo   (dsu_quo)
   );

   tsa_ram #(
      .WIDTH (EW),
      .DEPTH (RAM_DEPTH)
   ) u_matrix (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire
